@@ sv/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int CMD_W   = 2;
	localparam int OUTER_W = 4;
	localparam int INNER_W = 4;
	localparam int PAGE_W  = 8;
	localparam int SLOT_W  = 6;

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [OUTER_W-1:0] outer_index;
		logic [INNER_W-1:0] inner_index;
	} in_t;

	typedef struct packed {
		logic              hit;
		logic              evicted;
		logic [SLOT_W-1:0] slot;
		logic [PAGE_W-1:0] victim_page;
		logic              victim_dirty;
	} out_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic idle_res;
		logic lookup;
		logic hit_upd;
		logic fill_upd;
		logic vic_start;
		logic vic_step;
		logic evict_upd;
	} ctl_cmd_t;

	typedef struct packed {
		logic match;
		logic scan_done;
		logic full;
		logic vic_found;
	} dp_stat_t;

endpackage

@@ sv/clock_page_replacement.sv @@
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock and enhanced clock page replacement over a ring of frame slots.
// ----------------------------------------------------------------------------
// Channel   Ports                      Handshake
// request   request (in_t)             taken when start is high and busy low
// result    result (out_t)             valid for one cycle while done is high
// config    cfg_we, cfg_wdata          written when cfg_we is high
//
// Clear and unused commands finish in idle. An access reads one resident page
// per cycle in slot order until a hit or until all filled slots are read; a miss
// then fills the next free slot. A miss on a full ring instead walks the hand one
// slot per cycle, at most FRAMES plus one slots for plain clock or three passes
// plus one slot for enhanced clock, and then replaces the victim. The result is
// registered. Reset empties the ring; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module clock_page_replacement import cpr_pkg::*; #(
	parameter int FRAMES            = 4,
	parameter int ENTRIES_PER_TABLE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  request,
	output logic done,
	output out_t result,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	cpr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (request.cmd),
		.busy  (busy),
		.ctl   (ctl),
		.stat  (stat)
	);

	cpr_datapath #(
		.FRAMES           (FRAMES),
		.ENTRIES_PER_TABLE(ENTRIES_PER_TABLE)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.ctl      (ctl),
		.stat     (stat),
		.done     (done),
		.result   (result)
	);

endmodule

@@ sv/cpr_ram.sv @@
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/cpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpr_ctrl
// Controller: sequences lookup, fill, victim search and eviction.
// ----------------------------------------------------------------------------
module cpr_ctrl import cpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] cmd,
	output logic             busy,
	output ctl_cmd_t         ctl,
	input  dp_stat_t         stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_SEARCH,
		S_EVICT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_READ, CMD_WRITE: begin
							ctl.load  = 1'b1;
							state_nxt = S_LOOKUP;
						end
						CMD_CLEAR: begin
							ctl.clear = 1'b1;
						end
						default: begin
							ctl.idle_res = 1'b1;
						end
					endcase
				end
			end
			S_LOOKUP: begin
				ctl.lookup = 1'b1;
				if (stat.match) begin
					ctl.hit_upd = 1'b1;
					state_nxt   = S_IDLE;
				end else if (stat.scan_done) begin
					if (stat.full) begin
						ctl.vic_start = 1'b1;
						state_nxt     = S_SEARCH;
					end else begin
						ctl.fill_upd = 1'b1;
						state_nxt    = S_IDLE;
					end
				end
			end
			S_SEARCH: begin
				ctl.vic_step = 1'b1;
				if (stat.vic_found) begin
					state_nxt = S_EVICT;
				end
			end
			S_EVICT: begin
				ctl.evict_upd = 1'b1;
				state_nxt     = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ sv/cpr_datapath.sv @@
// ----------------------------------------------------------------------------
// cpr_datapath
// Datapath: page store, use and dirty bits, fill count, clock hand, result.
// ----------------------------------------------------------------------------
module cpr_datapath import cpr_pkg::*; #(
	parameter int FRAMES            = 4,
	parameter int ENTRIES_PER_TABLE = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_t      request,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  ctl_cmd_t ctl,
	output dp_stat_t stat,
	output logic     done,
	output out_t     result
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int PROD_W = PAGE_W + $clog2(ENTRIES_PER_TABLE + 1);
	localparam logic [IDX_W-1:0] LAST     = IDX_W'(FRAMES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAMES);

	logic              enh_q;
	logic [PAGE_W-1:0] page_q;
	logic              wr_q;
	logic [FRAMES-1:0] use_q;
	logic [FRAMES-1:0] dirty_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  hand_q;
	logic [CNT_W-1:0]  rd_ptr_q;
	logic              rd_vld_q;
	logic [IDX_W-1:0]  cmp_ptr_q;
	logic [IDX_W-1:0]  vic_q;
	logic [IDX_W-1:0]  step_q;
	logic              pass_q;
	logic              done_q;
	out_t              res_q;

	logic [PROD_W-1:0] prod;
	logic              rd_avail;
	logic              rd_issue;
	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  waddr;
	logic              ram_we;
	logic [PAGE_W-1:0] rdata;
	logic [IDX_W-1:0]  fill_idx;
	logic              clean;

	function automatic logic [IDX_W-1:0] nxt_slot(input logic [IDX_W-1:0] s);
		return (s == LAST) ? '0 : s + 1'b1;
	endfunction

	assign prod = PROD_W'(request.outer_index) * PROD_W'(ENTRIES_PER_TABLE)
		+ PROD_W'(request.inner_index);

	assign fill_idx = fill_q[IDX_W-1:0];
	assign rd_avail = (rd_ptr_q < fill_q);
	assign rd_issue = ctl.lookup & rd_avail;
	assign raddr    = ctl.lookup ? rd_ptr_q[IDX_W-1:0] : vic_q;
	assign ram_we   = ctl.fill_upd | ctl.evict_upd;
	assign waddr    = ctl.evict_upd ? vic_q : fill_idx;
	assign clean    = !use_q[vic_q] && !dirty_q[vic_q];

	assign stat.match     = rd_vld_q && (rdata == page_q);
	assign stat.scan_done = !rd_avail && !rd_vld_q;
	assign stat.full      = (fill_q == FULL_CNT);
	assign stat.vic_found = (enh_q && !pass_q) ? clean : !use_q[vic_q];

	cpr_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(FRAMES)
	) u_page_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(page_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enh_q     <= 1'b0;
			use_q     <= '0;
			dirty_q   <= '0;
			fill_q    <= '0;
			hand_q    <= '0;
			rd_ptr_q  <= '0;
			rd_vld_q  <= 1'b0;
			cmp_ptr_q <= '0;
			vic_q     <= '0;
			step_q    <= '0;
			pass_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= ctl.clear | ctl.idle_res | ctl.hit_upd | ctl.fill_upd | ctl.evict_upd;
			if (cfg_we) begin
				enh_q <= cfg_wdata;
			end
			if (ctl.load) begin
				rd_ptr_q <= '0;
				rd_vld_q <= 1'b0;
			end else begin
				rd_vld_q  <= rd_issue;
				cmp_ptr_q <= rd_ptr_q[IDX_W-1:0];
				if (rd_issue) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (ctl.clear) begin
				use_q   <= '0;
				dirty_q <= '0;
				fill_q  <= '0;
				hand_q  <= '0;
			end
			if (ctl.hit_upd) begin
				use_q[cmp_ptr_q] <= 1'b1;
				if (wr_q) begin
					dirty_q[cmp_ptr_q] <= 1'b1;
				end
			end
			if (ctl.fill_upd) begin
				use_q[fill_idx]   <= 1'b1;
				dirty_q[fill_idx] <= wr_q;
				fill_q            <= fill_q + 1'b1;
			end
			if (ctl.vic_start) begin
				vic_q  <= hand_q;
				step_q <= '0;
				pass_q <= 1'b0;
			end
			if (ctl.vic_step && !stat.vic_found) begin
				if (!enh_q || pass_q) begin
					use_q[vic_q] <= 1'b0;
				end
				vic_q <= nxt_slot(vic_q);
				if (step_q == LAST) begin
					step_q <= '0;
					pass_q <= ~pass_q;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (ctl.evict_upd) begin
				use_q[vic_q]   <= 1'b1;
				dirty_q[vic_q] <= wr_q;
				hand_q         <= nxt_slot(vic_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			page_q <= prod[PAGE_W-1:0];
			wr_q   <= (request.cmd == CMD_WRITE);
		end
		if (ctl.clear || ctl.idle_res) begin
			res_q <= '0;
		end
		if (ctl.hit_upd) begin
			res_q.hit          <= 1'b1;
			res_q.evicted      <= 1'b0;
			res_q.slot         <= SLOT_W'(cmp_ptr_q);
			res_q.victim_page  <= '0;
			res_q.victim_dirty <= 1'b0;
		end
		if (ctl.fill_upd) begin
			res_q.hit          <= 1'b0;
			res_q.evicted      <= 1'b0;
			res_q.slot         <= SLOT_W'(fill_q);
			res_q.victim_page  <= '0;
			res_q.victim_dirty <= 1'b0;
		end
		if (ctl.evict_upd) begin
			res_q.hit          <= 1'b0;
			res_q.evicted      <= 1'b1;
			res_q.slot         <= SLOT_W'(vic_q);
			res_q.victim_page  <= rdata;
			res_q.victim_dirty <= dirty_q[vic_q];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
